// ===== hdl/chmsc_pkg.sv =====
// Shared constants, codes and the pointer-word check for the cons-cell collector.
// No dependencies; used by the collector top level.
`timescale 1ns / 1ps

package chmsc_pkg;

    localparam int HEAP_CELLS_DEF = 4096;
    localparam int ROOT_DEPTH_DEF = 1024;

    localparam int WORD_W     = 64;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int LIMIT_W    = 13;
    localparam int FREED_W    = 13;
    localparam int IN_DATA_W  = 4 * WORD_W;
    localparam int OUT_DATA_W = WORD_W + STATUS_W + FREED_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam logic [FUNC_W-1:0] FUNC_ROOT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEAD  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_TAIL  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ROOTOVF = 2'd3;

    // A word names a cell when bit 0 is set, it is not negative, and the
    // index (word shifted right by two) lies below the bound.
    function automatic logic ptr_ok(input logic [WORD_W-1:0] w,
                                    input logic [WORD_W-1:0] bound);
        return w[0] && !w[WORD_W-1] && ({2'b00, w[WORD_W-1:2]} < bound);
    endfunction

endpackage

// ===== hdl/chmsc_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
// No dependencies; instantiated by the collector top level for every store.
`timescale 1ns / 1ps

module chmsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cons_heap_mark_sweep_collector.sv =====
// Mark-sweep collector over a heap of two-word cons cells, with its sequencer.
// Depends on chmsc_pkg and chmsc_ram.
`timescale 1ns / 1ps
// Root add, cell read and bump allocate go from idle straight to the result; an
// allocate from the free list passes through S_TAKE first. A collecting allocate
// marks from every root and the new head and tail words, then sweeps the cells
// in use; each RAM has a single read port. One word is worked on at a time.
// Reset clears all control state at once; no clearing pass is needed because a
// cell's mark bit is written to zero when the cell is first bump allocated.

module cons_heap_mark_sweep_collector #(
    parameter int HEAP_CELLS = chmsc_pkg::HEAP_CELLS_DEF,
    parameter int ROOT_DEPTH = chmsc_pkg::ROOT_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // root_word, head_word, tail_word, address_word (lowest bits first)
    input  logic [chmsc_pkg::IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic [chmsc_pkg::FUNC_W-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // data_out, status, freed_count, collected (lowest bits first)
    output logic [chmsc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [chmsc_pkg::LIMIT_W-1:0]    cfg_wdata
);

    localparam int CW    = $clog2(HEAP_CELLS);
    localparam int CNT_W = $clog2(HEAP_CELLS + 1);
    localparam int RAW   = (ROOT_DEPTH > 1) ? $clog2(ROOT_DEPTH) : 1;
    localparam int RCW   = $clog2(ROOT_DEPTH + 1);
    localparam int W     = chmsc_pkg::WORD_W;

    // One-hot sequencer states.
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DONE  = 12'b0000_0000_0010,
        S_TAKE  = 12'b0000_0000_0100,
        S_MNEXT = 12'b0000_0000_1000,
        S_RGET  = 12'b0000_0001_0000,
        S_VCHK  = 12'b0000_0010_0000,
        S_TRACE = 12'b0000_0100_0000,
        S_TPOP  = 12'b0000_1000_0000,
        S_TCELL = 12'b0001_0000_0000,
        S_TTAIL = 12'b0010_0000_0000,
        S_SWEEP = 12'b0100_0000_0000,
        S_SCHK  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cells_used_reg, cells_used_next;
    logic [CW-1:0]    free_first_reg, free_first_next;
    logic [CW-1:0]    free_last_reg, free_last_next;
    logic             free_ne_reg, free_ne_next;
    logic [RCW-1:0]   root_count_reg, root_count_next;
    logic [RCW-1:0]   ridx_reg, ridx_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [chmsc_pkg::LIMIT_W-1:0] heap_limit_reg;
    logic             h_done_reg, h_done_next;
    logic             t_done_reg, t_done_next;
    logic [CW-1:0]    vidx_reg, vidx_next;
    logic             ret_tail_reg, ret_tail_next;
    logic [CNT_W-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0] freed_reg, freed_next;
    logic             coll_reg, coll_next;
    logic [W-1:0]     head_w_reg, head_w_next;
    logic [W-1:0]     tail_w_reg, tail_w_next;
    logic [W-1:0]     res_data_reg, res_data_next;
    logic [chmsc_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic             res_mem_reg, res_mem_next;
    logic             res_tail_reg, res_tail_next;
    logic             m_tvalid_reg;
    logic [chmsc_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // RAM ports.
    logic             cell_we_h, cell_we_t, cell_re;
    logic [CW-1:0]    cell_waddr, cell_raddr;
    logic [W-1:0]     cell_wh, cell_wt, head_rd, tail_rd;
    logic             mark_we, mark_wd, mark_re, mark_rd;
    logic [CW-1:0]    mark_waddr, mark_raddr;
    logic             stk_we, stk_re;
    logic [CW-1:0]    stk_waddr, stk_raddr, stk_wd, stk_rd;
    logic             root_we, root_re;
    logic [RAW-1:0]   root_waddr, root_raddr;
    logic [CW-1:0]    root_wd, root_rd;

    logic [W-1:0]     in_root, in_head, in_tail, in_addr;
    logic [W-1:0]     used_bound;
    logic [CNT_W-1:0] depth_dec;
    logic             bump_ok;
    logic             load;
    logic [W-1:0]     out_data;

    assign in_root    = s_tdata[W-1:0];
    assign in_head    = s_tdata[2*W-1:W];
    assign in_tail    = s_tdata[3*W-1:2*W];
    assign in_addr    = s_tdata[4*W-1:3*W];
    assign used_bound = W'(cells_used_reg);
    assign depth_dec  = depth_reg - CNT_W'(1);
    // Bump allocation while below both the configured limit and the heap size.
    assign bump_ok    = (32'(cells_used_reg) < 32'(heap_limit_reg))
                     && (32'(cells_used_reg) < 32'(HEAP_CELLS));

    assign s_tready = (state_reg == S_IDLE);
    assign load     = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign out_data = res_mem_reg ? (res_tail_reg ? tail_rd : head_rd) : res_data_reg;

    chmsc_ram #(.WIDTH(W), .DEPTH(HEAP_CELLS)) u_head (
        .clk(clk), .we(cell_we_h), .waddr(cell_waddr), .wdata(cell_wh),
        .re(cell_re), .raddr(cell_raddr), .rdata(head_rd)
    );
    chmsc_ram #(.WIDTH(W), .DEPTH(HEAP_CELLS)) u_tail (
        .clk(clk), .we(cell_we_t), .waddr(cell_waddr), .wdata(cell_wt),
        .re(cell_re), .raddr(cell_raddr), .rdata(tail_rd)
    );
    chmsc_ram #(.WIDTH(1), .DEPTH(HEAP_CELLS)) u_mark (
        .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wd),
        .re(mark_re), .raddr(mark_raddr), .rdata(mark_rd)
    );
    chmsc_ram #(.WIDTH(CW), .DEPTH(HEAP_CELLS)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wd),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
    );
    chmsc_ram #(.WIDTH(CW), .DEPTH(ROOT_DEPTH)) u_root (
        .clk(clk), .we(root_we), .waddr(root_waddr), .wdata(root_wd),
        .re(root_re), .raddr(root_raddr), .rdata(root_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        cells_used_next = cells_used_reg;
        free_first_next = free_first_reg;
        free_last_next  = free_last_reg;
        free_ne_next    = free_ne_reg;
        root_count_next = root_count_reg;
        ridx_next       = ridx_reg;
        depth_next      = depth_reg;
        h_done_next     = h_done_reg;
        t_done_next     = t_done_reg;
        vidx_next       = vidx_reg;
        ret_tail_next   = ret_tail_reg;
        sweep_next      = sweep_reg;
        freed_next      = freed_reg;
        coll_next       = coll_reg;
        head_w_next     = head_w_reg;
        tail_w_next     = tail_w_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_mem_next    = res_mem_reg;
        res_tail_next   = res_tail_reg;

        cell_we_h  = 1'b0;
        cell_we_t  = 1'b0;
        cell_waddr = free_first_reg;
        cell_wh    = head_w_reg;
        cell_wt    = tail_w_reg;
        cell_re    = 1'b0;
        cell_raddr = free_first_reg;
        mark_we    = 1'b0;
        mark_waddr = vidx_reg;
        mark_wd    = 1'b0;
        mark_re    = 1'b0;
        mark_raddr = vidx_reg;
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[CW-1:0];
        stk_wd     = vidx_reg;
        stk_re     = 1'b0;
        stk_raddr  = depth_dec[CW-1:0];
        root_we    = 1'b0;
        root_waddr = root_count_reg[RAW-1:0];
        root_wd    = in_root[CW+1:2];
        root_re    = 1'b0;
        root_raddr = ridx_reg[RAW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    freed_next      = '0;
                    coll_next       = 1'b0;
                    res_mem_next    = 1'b0;
                    res_tail_next   = 1'b0;
                    res_data_next   = '0;
                    res_status_next = chmsc_pkg::ST_OK;
                    head_w_next     = in_head;
                    tail_w_next     = in_tail;
                    state_next      = S_DONE;
                    case (s_tuser)
                        chmsc_pkg::FUNC_ROOT:
                        begin
                            if (root_count_reg == RCW'(ROOT_DEPTH))
                            begin
                                res_status_next = chmsc_pkg::ST_ROOTOVF;
                            end
                            else if (chmsc_pkg::ptr_ok(in_root, W'(HEAP_CELLS)))
                            begin
                                root_we         = 1'b1;
                                root_count_next = root_count_reg + RCW'(1);
                            end
                        end
                        chmsc_pkg::FUNC_ALLOC:
                        begin
                            if (bump_ok)
                            begin
                                cell_we_h       = 1'b1;
                                cell_we_t       = 1'b1;
                                cell_waddr      = cells_used_reg[CW-1:0];
                                cell_wh         = in_head;
                                cell_wt         = in_tail;
                                mark_we         = 1'b1;
                                mark_waddr      = cells_used_reg[CW-1:0];
                                res_data_next   = W'(cells_used_reg);
                                cells_used_next = cells_used_reg + CNT_W'(1);
                                root_count_next = '0;
                            end
                            else if (free_ne_reg)
                            begin
                                cell_re    = 1'b1;
                                state_next = S_TAKE;
                            end
                            else
                            begin
                                coll_next   = 1'b1;
                                ridx_next   = '0;
                                h_done_next = 1'b0;
                                t_done_next = 1'b0;
                                state_next  = S_MNEXT;
                            end
                        end
                        default:
                        begin
                            if (chmsc_pkg::ptr_ok(in_addr, used_bound))
                            begin
                                cell_re       = 1'b1;
                                cell_raddr    = in_addr[CW+1:2];
                                res_mem_next  = 1'b1;
                                res_tail_next = (s_tuser == chmsc_pkg::FUNC_TAIL);
                            end
                            else
                            begin
                                res_status_next = chmsc_pkg::ST_BADADDR;
                            end
                        end
                    endcase
                end
            end
            S_TAKE:
            begin
                // head_rd holds the link to the next free cell.
                cell_we_h       = 1'b1;
                cell_we_t       = 1'b1;
                res_data_next   = W'(free_first_reg);
                root_count_next = '0;
                if ((free_first_reg != free_last_reg) && (head_rd < W'(HEAP_CELLS)))
                begin
                    free_first_next = head_rd[CW-1:0];
                end
                else
                begin
                    free_ne_next = 1'b0;
                end
                state_next = S_DONE;
            end
            S_MNEXT:
            begin
                if (ridx_reg < root_count_reg)
                begin
                    root_re    = 1'b1;
                    ridx_next  = ridx_reg + RCW'(1);
                    state_next = S_RGET;
                end
                else if (!h_done_reg)
                begin
                    h_done_next   = 1'b1;
                    ret_tail_next = 1'b0;
                    if (chmsc_pkg::ptr_ok(head_w_reg, used_bound))
                    begin
                        mark_re    = 1'b1;
                        mark_raddr = head_w_reg[CW+1:2];
                        vidx_next  = head_w_reg[CW+1:2];
                        state_next = S_VCHK;
                    end
                end
                else if (!t_done_reg)
                begin
                    t_done_next   = 1'b1;
                    ret_tail_next = 1'b0;
                    if (chmsc_pkg::ptr_ok(tail_w_reg, used_bound))
                    begin
                        mark_re    = 1'b1;
                        mark_raddr = tail_w_reg[CW+1:2];
                        vidx_next  = tail_w_reg[CW+1:2];
                        state_next = S_VCHK;
                    end
                end
                else
                begin
                    sweep_next = '0;
                    state_next = S_SWEEP;
                end
            end
            S_RGET:
            begin
                ret_tail_next = 1'b0;
                if (CNT_W'(root_rd) < cells_used_reg)
                begin
                    mark_re    = 1'b1;
                    mark_raddr = root_rd;
                    vidx_next  = root_rd;
                    state_next = S_VCHK;
                end
                else
                begin
                    state_next = S_TRACE;
                end
            end
            S_VCHK:
            begin
                if (!mark_rd)
                begin
                    mark_we = 1'b1;
                    mark_wd = 1'b1;
                    if (depth_reg != CNT_W'(HEAP_CELLS))
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + CNT_W'(1);
                    end
                end
                state_next = ret_tail_reg ? S_TTAIL : S_TRACE;
            end
            S_TRACE:
            begin
                if (depth_reg != '0)
                begin
                    stk_re     = 1'b1;
                    depth_next = depth_dec;
                    state_next = S_TPOP;
                end
                else
                begin
                    state_next = S_MNEXT;
                end
            end
            S_TPOP:
            begin
                cell_re    = 1'b1;
                cell_raddr = stk_rd;
                state_next = S_TCELL;
            end
            S_TCELL:
            begin
                ret_tail_next = 1'b1;
                if (chmsc_pkg::ptr_ok(head_rd, used_bound))
                begin
                    mark_re    = 1'b1;
                    mark_raddr = head_rd[CW+1:2];
                    vidx_next  = head_rd[CW+1:2];
                    state_next = S_VCHK;
                end
                else
                begin
                    state_next = S_TTAIL;
                end
            end
            S_TTAIL:
            begin
                ret_tail_next = 1'b0;
                if (chmsc_pkg::ptr_ok(tail_rd, used_bound))
                begin
                    mark_re    = 1'b1;
                    mark_raddr = tail_rd[CW+1:2];
                    vidx_next  = tail_rd[CW+1:2];
                    state_next = S_VCHK;
                end
                else
                begin
                    state_next = S_TRACE;
                end
            end
            S_SWEEP:
            begin
                if (sweep_reg < cells_used_reg)
                begin
                    mark_re    = 1'b1;
                    mark_raddr = sweep_reg[CW-1:0];
                    state_next = S_SCHK;
                end
                else if (free_ne_reg)
                begin
                    cell_re    = 1'b1;
                    state_next = S_TAKE;
                end
                else
                begin
                    res_status_next = chmsc_pkg::ST_OOM;
                    root_count_next = '0;
                    state_next      = S_DONE;
                end
            end
            S_SCHK:
            begin
                if (mark_rd)
                begin
                    mark_we    = 1'b1;
                    mark_waddr = sweep_reg[CW-1:0];
                end
                else
                begin
                    if (!free_ne_reg)
                    begin
                        free_first_next = sweep_reg[CW-1:0];
                        free_ne_next    = 1'b1;
                    end
                    else
                    begin
                        // Chain the cell behind the current last free cell.
                        cell_we_h  = 1'b1;
                        cell_waddr = free_last_reg;
                        cell_wh    = W'(sweep_reg);
                    end
                    free_last_next = sweep_reg[CW-1:0];
                    freed_next     = freed_reg + CNT_W'(1);
                end
                sweep_next = sweep_reg + CNT_W'(1);
                state_next = S_SWEEP;
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cells_used_reg <= '0;
            free_first_reg <= '0;
            free_last_reg  <= '0;
            free_ne_reg    <= 1'b0;
            root_count_reg <= '0;
            ridx_reg       <= '0;
            depth_reg      <= '0;
            heap_limit_reg <= chmsc_pkg::LIMIT_RESET;
            h_done_reg     <= 1'b0;
            t_done_reg     <= 1'b0;
            ret_tail_reg   <= 1'b0;
            sweep_reg      <= '0;
            freed_reg      <= '0;
            coll_reg       <= 1'b0;
            res_mem_reg    <= 1'b0;
            res_tail_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cells_used_reg <= cells_used_next;
            free_first_reg <= free_first_next;
            free_last_reg  <= free_last_next;
            free_ne_reg    <= free_ne_next;
            root_count_reg <= root_count_next;
            ridx_reg       <= ridx_next;
            depth_reg      <= depth_next;
            h_done_reg     <= h_done_next;
            t_done_reg     <= t_done_next;
            ret_tail_reg   <= ret_tail_next;
            sweep_reg      <= sweep_next;
            freed_reg      <= freed_next;
            coll_reg       <= coll_next;
            res_mem_reg    <= res_mem_next;
            res_tail_reg   <= res_tail_next;
            if (cfg_we)
            begin
                heap_limit_reg <= cfg_wdata;
            end
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        vidx_reg       <= vidx_next;
        head_w_reg     <= head_w_next;
        tail_w_reg     <= tail_w_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        if (load)
        begin
            m_tdata_reg <= {coll_reg, chmsc_pkg::FREED_W'(freed_reg), res_status_reg, out_data};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The mark stack is drained before every collection returns to idle.
    a_stack_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (depth_reg == '0))
        else $error("mark stack not empty while idle");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cells_used_reg) <= 32'(HEAP_CELLS))
        else $error("cells in use exceed heap size");

    a_freed_only_collect: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !coll_reg) |-> (freed_reg == '0))
        else $error("freed count without a collection");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(root_count_reg) <= 32'(ROOT_DEPTH))
        else $error("root count exceeds root store");

    a_alloc_clears_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAKE) |=> (root_count_reg == '0))
        else $error("roots not cleared after allocate");

endmodule
